@@ sv/stc_pkg.sv @@
package stc_pkg;

  localparam int CB     = 16;            // coordinate width, Q8.8
  localparam int NB     = 16;            // normal component width, Q2.14
  localparam int NF     = 14;
  localparam int WB     = 16;            // weight fraction bits
  localparam int DSHIFT = 2 * CB - 24;   // drop before region products

  localparam int E_W  = CB + 1;          // edge and offset vectors
  localparam int PD_W = 2 * E_W;         // one dot product term
  localparam int D_W  = PD_W + 2;        // d1..d6
  localparam int S_W  = D_W - DSHIFT;    // shifted d
  localparam int PV_W = 2 * S_W;         // region product
  localparam int V_W  = PV_W + 4;        // va, vb, vc and denominators
  localparam int N_W  = 46;              // divider operand width after halving
  localparam int R_W  = N_W + 1;         // partial remainder
  localparam int Q_W  = WB + 1;          // weight, up to 1.0
  localparam int K_W  = 4;               // halving count
  localparam int PO_W = E_W + NB;        // offset times normal term
  localparam int L_W  = PO_W + 4;        // push length
  localparam int PM_W = NB + L_W;        // normal times length
  localparam int PA_W = E_W + Q_W + 1;   // edge times weight
  localparam int PT_W = PA_W + 2;        // rounded weighted sum

  localparam logic signed [31:0] CMAX = 32'((64'sd1 <<< (CB - 1)) - 1);
  localparam logic signed [31:0] CMIN = -32'(64'sd1 <<< (CB - 1));

  typedef logic [2:0][CB-1:0]  vc_t;
  typedef logic [2:0][E_W-1:0] ve_t;

  typedef struct packed {
    vc_t           ctr;
    vc_t           p0;
    vc_t           p1;
    vc_t           p2;
    ve_t           e01;
    ve_t           e02;
    ve_t           e12;
    logic [CB-1:0] rad;
  } geo_t;

  typedef struct packed {
    vc_t           base;
    ve_t           ea;
    ve_t           eb;
    vc_t           ctr;
    logic [CB-1:0] rad;
    vc_t           push;
    logic          za;
    logic          oa;
    logic          zb;
    logic          ob;
  } side_t;

  typedef struct packed {
    logic [N_W-1:0] num_a;
    logic [N_W-1:0] num_b;
    logic [N_W-1:0] den;
    side_t          side;
  } div_in_t;

  typedef struct packed {
    logic [Q_W-1:0] q_a;
    logic [Q_W-1:0] q_b;
    side_t          side;
  } div_out_t;

  // exact difference of two signed coordinates
  function automatic logic [E_W-1:0] sub_c(logic [CB-1:0] a, logic [CB-1:0] b);
    return {a[CB-1], a} - {b[CB-1], b};
  endfunction

  function automatic logic [CB-1:0] sat_c(logic signed [31:0] x);
    if (x > CMAX) return CMAX[CB-1:0];
    if (x < CMIN) return CMIN[CB-1:0];
    return x[CB-1:0];
  endfunction

  // one restoring division step: {quotient bit, new remainder}
  function automatic logic [R_W:0] div_step(logic [R_W-1:0] r, logic [N_W-1:0] d);
    logic ge;
    ge = (r >= {1'b0, d});
    return ge ? {1'b1, r - {1'b0, d}} : {1'b0, r};
  endfunction

endpackage

@@ sv/stc_div.sv @@
module stc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               vld_i,
  input  stc_pkg::div_in_t   in_i,
  output logic               vld_o,
  output stc_pkg::div_out_t  out_o
);
  import stc_pkg::*;

  logic [R_W-1:0] ra_q [Q_W];
  logic [R_W-1:0] rb_q [Q_W];
  logic [Q_W-1:0] qa_q [Q_W];
  logic [Q_W-1:0] qb_q [Q_W];
  logic [N_W-1:0] den_q [Q_W];
  side_t          side_q [Q_W];
  logic [Q_W-1:0] vld_q;

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [R_W-1:0] ra_in, rb_in;
    logic [Q_W-1:0] qa_in, qb_in;
    logic [N_W-1:0] d_in;
    side_t          s_in;
    logic           v_in;
    logic [R_W:0]   sa, sb;

    if (j == 0) begin : g_first
      // first step weighs 1.0 and needs no shift
      assign ra_in = {1'b0, in_i.num_a};
      assign rb_in = {1'b0, in_i.num_b};
      assign qa_in = '0;
      assign qb_in = '0;
      assign d_in  = in_i.den;
      assign s_in  = in_i.side;
      assign v_in  = vld_i;
    end else begin : g_next
      assign ra_in = {ra_q[j-1][R_W-2:0], 1'b0};
      assign rb_in = {rb_q[j-1][R_W-2:0], 1'b0};
      assign qa_in = qa_q[j-1];
      assign qb_in = qb_q[j-1];
      assign d_in  = den_q[j-1];
      assign s_in  = side_q[j-1];
      assign v_in  = vld_q[j-1];
    end

    assign sa = div_step(ra_in, d_in);
    assign sb = div_step(rb_in, d_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ra_q[j]   <= sa[R_W-1:0];
        rb_q[j]   <= sb[R_W-1:0];
        qa_q[j]   <= {qa_in[Q_W-2:0], sa[R_W]};
        qb_q[j]   <= {qb_in[Q_W-2:0], sb[R_W]};
        den_q[j]  <= d_in;
        side_q[j] <= s_in;
      end
    end
  end

  assign vld_o      = vld_q[Q_W-1];
  assign out_o.q_a  = qa_q[Q_W-1];
  assign out_o.q_b  = qb_q[Q_W-1];
  assign out_o.side = side_q[Q_W-1];

endmodule

@@ sv/sphere_triangle_collide.sv @@
// Throughput: one item per cycle while the output item is taken.
// The 17-stage weight divider sets most of the pipeline depth.
// The whole pipeline advances together and holds while the output item is not taken.
// Reset: asynchronous, active low; clears all valid bits, payload is not reset.
module sphere_triangle_collide (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // sphere_center[47:0], sphere_radius[63:48], tri_p0[111:64], tri_p1[159:112],
  // tri_p2[207:160], tri_normal[255:208]
  input  logic [255:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // hit[0], contact_x[16:1], contact_y[32:17], contact_z[48:33],
  // push_x[64:49], push_y[80:65], push_z[96:81], zero fill[103:97]
  output logic [103:0] m_axis_tdata_o
);
  import stc_pkg::*;

  localparam logic signed [PM_W:0] PHALF = (PM_W + 1)'(1) << (2 * NF - 1);
  localparam logic signed [PT_W-1:0] THALF = PT_W'(1) << (WB - 1);

  logic en;
  logic [8:0] pre_v_q;
  logic [2:0] post_v_q;
  logic out_vld_q;
  logic div_vld;

  assign en = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_v_q   <= '0;
      post_v_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      pre_v_q   <= {pre_v_q[7:0], s_axis_tvalid_i};
      post_v_q  <= {post_v_q[1:0], div_vld};
      out_vld_q <= post_v_q[2];
    end
  end

  // ---- stage 1: unpack, edge and offset vectors
  geo_t g1_d, g1_q;
  ve_t  w0_d, w1_d, w2_d, off_d, w0_q, w1_q, w2_q, off_q;
  logic [2:0][NB-1:0] n1_q;

  always_comb begin
    g1_d.rad = s_axis_tdata_i[63:48];
    for (int i = 0; i < 3; i++) begin
      g1_d.ctr[i] = s_axis_tdata_i[i*CB +: CB];
      g1_d.p0[i]  = s_axis_tdata_i[64 + i*CB +: CB];
      g1_d.p1[i]  = s_axis_tdata_i[112 + i*CB +: CB];
      g1_d.p2[i]  = s_axis_tdata_i[160 + i*CB +: CB];
    end
    for (int i = 0; i < 3; i++) begin
      g1_d.e01[i] = sub_c(g1_d.p1[i], g1_d.p0[i]);
      g1_d.e02[i] = sub_c(g1_d.p2[i], g1_d.p0[i]);
      g1_d.e12[i] = sub_c(g1_d.p2[i], g1_d.p1[i]);
      w0_d[i]     = sub_c(g1_d.ctr[i], g1_d.p0[i]);
      w1_d[i]     = sub_c(g1_d.ctr[i], g1_d.p1[i]);
      w2_d[i]     = sub_c(g1_d.ctr[i], g1_d.p2[i]);
      off_d[i]    = sub_c(g1_d.p0[i], g1_d.ctr[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_q  <= g1_d;
      w0_q  <= w0_d;
      w1_q  <= w1_d;
      w2_q  <= w2_d;
      off_q <= off_d;
      n1_q  <= s_axis_tdata_i[255:208];
    end
  end

  // ---- stage 2: dot product terms
  logic signed [PD_W-1:0] pd_d [6][3];
  logic signed [PD_W-1:0] pd_q [6][3];
  logic signed [PO_W-1:0] po_d [3];
  logic signed [PO_W-1:0] po_q [3];
  geo_t g2_q;
  logic [2:0][NB-1:0] n2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pd_d[0][i] = $signed(g1_q.e01[i]) * $signed(w0_q[i]);
      pd_d[1][i] = $signed(g1_q.e02[i]) * $signed(w0_q[i]);
      pd_d[2][i] = $signed(g1_q.e01[i]) * $signed(w1_q[i]);
      pd_d[3][i] = $signed(g1_q.e02[i]) * $signed(w1_q[i]);
      pd_d[4][i] = $signed(g1_q.e01[i]) * $signed(w2_q[i]);
      pd_d[5][i] = $signed(g1_q.e02[i]) * $signed(w2_q[i]);
      po_d[i]    = $signed(off_q[i]) * $signed(n1_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pd_q <= pd_d;
      po_q <= po_d;
      g2_q <= g1_q;
      n2_q <= n1_q;
    end
  end

  // ---- stage 3: d1..d6 and push length
  logic signed [D_W-1:0] d_d [6];
  logic signed [D_W-1:0] d3_q [6];
  logic signed [L_W-1:0] len_d, len_q;
  geo_t g3_q;
  logic [2:0][NB-1:0] n3_q;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      d_d[k] = pd_q[k][0] + pd_q[k][1] + pd_q[k][2];
    end
    len_d = po_q[0] + po_q[1] + po_q[2] + $signed({1'b0, g2_q.rad, NF'(0)});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_q  <= d_d;
      len_q <= len_d;
      g3_q  <= g2_q;
      n3_q  <= n2_q;
    end
  end

  // ---- stage 4: region products and push products
  logic signed [S_W-1:0]  sd [6];
  logic signed [PV_W-1:0] pv_d [6];
  logic signed [PV_W-1:0] pv_q [6];
  logic signed [PM_W-1:0] pm_d [3];
  logic signed [PM_W-1:0] pm_q [3];
  logic signed [D_W-1:0]  d4_q [6];
  geo_t g4_q;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      sd[k] = d3_q[k][D_W-1:DSHIFT];
    end
    pv_d[0] = sd[0] * sd[3];  // d1*d4
    pv_d[1] = sd[2] * sd[1];  // d3*d2
    pv_d[2] = sd[4] * sd[1];  // d5*d2
    pv_d[3] = sd[0] * sd[5];  // d1*d6
    pv_d[4] = sd[2] * sd[5];  // d3*d6
    pv_d[5] = sd[4] * sd[3];  // d5*d4
    for (int i = 0; i < 3; i++) begin
      pm_d[i] = $signed(n3_q[i]) * len_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pv_q <= pv_d;
      pm_q <= pm_d;
      d4_q <= d3_q;
      g4_q <= g3_q;
    end
  end

  // ---- stage 5: va, vb, vc, edge terms, vertex tests, push rounding
  logic signed [V_W-1:0] va_q, vb_q, vc_q, de01_q, de02_q, a43_q, a56_q;
  logic signed [D_W-1:0] d1_5_q, d2_5_q;
  logic cp0_q, cp1_q, cp2_q, fe01_q, fe02_q;
  vc_t  push_d, push5_q;
  geo_t g5_q;

  always_comb begin
    logic signed [PM_W:0]        t;
    logic signed [PM_W-2*NF:0]   sh;
    for (int i = 0; i < 3; i++) begin
      t         = pm_q[i] + PHALF;
      sh        = t[PM_W:2*NF];
      push_d[i] = sat_c(32'(sh));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vc_q    <= V_W'(pv_q[0]) - V_W'(pv_q[1]);
      vb_q    <= V_W'(pv_q[2]) - V_W'(pv_q[3]);
      va_q    <= V_W'(pv_q[4]) - V_W'(pv_q[5]);
      de01_q  <= V_W'(d4_q[0]) - V_W'(d4_q[2]);
      de02_q  <= V_W'(d4_q[1]) - V_W'(d4_q[5]);
      a43_q   <= V_W'(d4_q[3]) - V_W'(d4_q[2]);
      a56_q   <= V_W'(d4_q[4]) - V_W'(d4_q[5]);
      d1_5_q  <= d4_q[0];
      d2_5_q  <= d4_q[1];
      cp0_q   <= (d4_q[0] <= 0) && (d4_q[1] <= 0);
      cp1_q   <= (d4_q[2] >= 0) && (d4_q[3] <= d4_q[2]);
      cp2_q   <= (d4_q[5] >= 0) && (d4_q[4] <= d4_q[5]);
      fe01_q  <= (d4_q[0] >= 0) && (d4_q[2] <= 0);
      fe02_q  <= (d4_q[1] >= 0) && (d4_q[5] <= 0);
      push5_q <= push_d;
      g5_q    <= g4_q;
    end
  end

  // ---- stage 6: face and edge12 denominators, edge tests
  logic signed [V_W-1:0] denf_q, de12_q, vb6_q, vc6_q, de01_6_q, de02_6_q, a43_6_q;
  logic signed [D_W-1:0] d1_6_q, d2_6_q;
  logic cp0_6_q, cp1_6_q, cp2_6_q, ce01_q, ce02_q, ce12_q;
  vc_t  push6_q;
  geo_t g6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      denf_q   <= va_q + vb_q + vc_q;
      de12_q   <= a43_q + a56_q;
      ce01_q   <= (vc_q <= 0) && fe01_q;
      ce02_q   <= (vb_q <= 0) && fe02_q;
      ce12_q   <= (va_q <= 0) && (a43_q >= 0) && (a56_q >= 0);
      vb6_q    <= vb_q;
      vc6_q    <= vc_q;
      de01_6_q <= de01_q;
      de02_6_q <= de02_q;
      a43_6_q  <= a43_q;
      d1_6_q   <= d1_5_q;
      d2_6_q   <= d2_5_q;
      cp0_6_q  <= cp0_q;
      cp1_6_q  <= cp1_q;
      cp2_6_q  <= cp2_q;
      push6_q  <= push5_q;
      g6_q     <= g5_q;
    end
  end

  // ---- stage 7: pick the region; unused lanes get weight zero
  vc_t base_d, base7_q;
  ve_t ea_d, eb_d, ea7_q, eb7_q;
  logic signed [V_W-1:0] na_d, nb_d, den_d, na7_q, nb7_q, den7_q;
  logic ua_d, ub_d, ua7_q, ub7_q;
  vc_t  push7_q;
  geo_t g7_q;

  always_comb begin
    base_d = g6_q.p0;
    ea_d   = g6_q.e01;
    eb_d   = g6_q.e02;
    na_d   = '0;
    nb_d   = '0;
    den_d  = '0;
    ua_d   = 1'b0;
    ub_d   = 1'b0;
    if (cp0_6_q) begin
      base_d = g6_q.p0;
    end else if (cp1_6_q) begin
      base_d = g6_q.p1;
    end else if (ce01_q) begin
      if (de01_6_q > 0) begin
        na_d  = V_W'(d1_6_q);
        den_d = de01_6_q;
        ua_d  = 1'b1;
      end
    end else if (cp2_6_q) begin
      base_d = g6_q.p2;
    end else if (ce02_q) begin
      if (de02_6_q > 0) begin
        ea_d  = g6_q.e02;
        na_d  = V_W'(d2_6_q);
        den_d = de02_6_q;
        ua_d  = 1'b1;
      end
    end else if (ce12_q) begin
      if (de12_q > 0) begin
        base_d = g6_q.p1;
        ea_d   = g6_q.e12;
        na_d   = a43_6_q;
        den_d  = de12_q;
        ua_d   = 1'b1;
      end
    end else begin
      if (denf_q > 0) begin
        na_d  = vb6_q;
        nb_d  = vc6_q;
        den_d = denf_q;
        ua_d  = 1'b1;
        ub_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      base7_q <= base_d;
      ea7_q   <= ea_d;
      eb7_q   <= eb_d;
      na7_q   <= na_d;
      nb7_q   <= nb_d;
      den7_q  <= den_d;
      ua7_q   <= ua_d;
      ub7_q   <= ub_d;
      push7_q <= push6_q;
      g7_q    <= g6_q;
    end
  end

  // ---- stage 8: clamp decisions and halving count
  logic [K_W-1:0] k_d, k8_q;
  logic signed [V_W-1:0] na8_q, nb8_q, den8_q;
  side_t side8_q;

  always_comb begin
    k_d = '0;
    for (int b = N_W; b < V_W - 1; b++) begin
      if (den7_q[b]) k_d = K_W'(b - N_W + 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      k8_q         <= k_d;
      na8_q        <= na7_q;
      nb8_q        <= nb7_q;
      den8_q       <= den7_q;
      side8_q.base <= base7_q;
      side8_q.ea   <= ea7_q;
      side8_q.eb   <= eb7_q;
      side8_q.ctr  <= g7_q.ctr;
      side8_q.rad  <= g7_q.rad;
      side8_q.push <= push7_q;
      side8_q.za   <= !ua7_q || (na7_q <= 0);
      side8_q.oa   <= na7_q >= den7_q;
      side8_q.zb   <= !ub7_q || (nb7_q <= 0);
      side8_q.ob   <= nb7_q >= den7_q;
    end
  end

  // ---- stage 9: halve operands into divider range
  div_in_t div_in_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      div_in_q.num_a <= N_W'($unsigned(na8_q) >> k8_q);
      div_in_q.num_b <= N_W'($unsigned(nb8_q) >> k8_q);
      div_in_q.den   <= N_W'($unsigned(den8_q) >> k8_q);
      div_in_q.side  <= side8_q;
    end
  end

  // ---- divider
  div_out_t div_out;

  stc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (pre_v_q[8]),
    .in_i   (div_in_q),
    .vld_o  (div_vld),
    .out_o  (div_out)
  );

  // ---- stage 10: weights and weighted edges
  logic [Q_W-1:0] wa, wb;
  logic signed [PA_W-1:0] pa_d [3];
  logic signed [PA_W-1:0] pb_d [3];
  logic signed [PA_W-1:0] pa_q [3];
  logic signed [PA_W-1:0] pb_q [3];
  side_t side10_q;

  always_comb begin
    wa = div_out.side.za ? '0 : (div_out.side.oa ? Q_W'(1) << WB : div_out.q_a);
    wb = div_out.side.zb ? '0 : (div_out.side.ob ? Q_W'(1) << WB : div_out.q_b);
    for (int i = 0; i < 3; i++) begin
      pa_d[i] = $signed(div_out.side.ea[i]) * $signed({1'b0, wa});
      pb_d[i] = $signed(div_out.side.eb[i]) * $signed({1'b0, wb});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q     <= pa_d;
      pb_q     <= pb_d;
      side10_q <= div_out.side;
    end
  end

  // ---- stage 11: closest point
  vc_t cp_d, cp11_q;
  vc_t ctr11_q, push11_q;
  logic [CB-1:0] rad11_q;

  always_comb begin
    logic signed [PT_W-1:0]    t;
    logic signed [PT_W-WB-1:0] sh;
    logic signed [PT_W-WB:0]   s;
    for (int i = 0; i < 3; i++) begin
      t       = PT_W'(pa_q[i]) + PT_W'(pb_q[i]) + THALF;
      sh      = t[PT_W-1:WB];
      s       = $signed(side10_q.base[i]) + sh;
      cp_d[i] = sat_c(32'(s));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cp11_q   <= cp_d;
      ctr11_q  <= side10_q.ctr;
      rad11_q  <= side10_q.rad;
      push11_q <= side10_q.push;
    end
  end

  // ---- stage 12: squared distance terms
  logic signed [PD_W-1:0] sq_d [3];
  logic signed [PD_W-1:0] sq_q [3];
  logic [2*CB-1:0] r2_q;
  vc_t cp12_q, push12_q;

  always_comb begin
    logic signed [E_W-1:0] df;
    for (int i = 0; i < 3; i++) begin
      df      = sub_c(cp11_q[i], ctr11_q[i]);
      sq_d[i] = df * df;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq_q     <= sq_d;
      r2_q     <= rad11_q * rad11_q;
      cp12_q   <= cp11_q;
      push12_q <= push11_q;
    end
  end

  // ---- stage 13: hit test, output item
  logic [PD_W+1:0] dist_sq;
  logic hit_d, hit_q;
  vc_t contact_q, push_q;

  assign dist_sq = (PD_W + 2)'($unsigned(sq_q[0])) + (PD_W + 2)'($unsigned(sq_q[1]))
                 + (PD_W + 2)'($unsigned(sq_q[2]));
  assign hit_d   = dist_sq <= (PD_W + 2)'(r2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      hit_q     <= hit_d;
      contact_q <= hit_d ? cp12_q : '0;
      push_q    <= hit_d ? push12_q : '0;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'd0, push_q[2], push_q[1], push_q[0],
                            contact_q[2], contact_q[1], contact_q[0], hit_q};

endmodule
